[hdl/streaming_fir_convolution_defines.svh]
// Assertion macros used by the checker of the streaming FIR block.
`ifndef STREAMING_FIR_CONVOLUTION_DEFINES_SVH
`define STREAMING_FIR_CONVOLUTION_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SFIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SFIR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sfir_pkg.sv]
// Shared types, constants and saturating arithmetic of the streaming FIR block.
package sfir_pkg;

  localparam int ACC_BITS       = 48;
  localparam int TAP_INDEX_BITS = 6;
  localparam int TAP_COUNT_BITS = 7;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // in_tuser codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // Broadcast control from the sequencer to every tap cell.
  typedef struct packed {
    logic coef_we;  // coefficient transfer, cell selected by tap index
    logic mul_en;   // load product registers from the held sample
    logic upd_en;   // advance the partial-sum chain
  } cell_ctrl_t;

  function automatic logic signed [ACC_BITS-1:0] acc_add_sat(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [ACC_BITS-1:0] b
  );
    logic signed [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_BITS-1:0];
  endfunction

endpackage

[hdl/sfir_cell.sv]
// One tap cell of the transposed FIR chain: coefficient, product and partial sum.
module sfir_cell
  import sfir_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18,
  localparam int CW = (TAP_COUNT_BITS > $clog2(MAX_TAPS + 1)) ?
                      TAP_COUNT_BITS : $clog2(MAX_TAPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctrl_t                    ctrl,
  input  logic [CW-1:0]                 teff,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic [TAP_INDEX_BITS-1:0]     tap_index_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  input  logic signed [ACC_BITS-1:0]    ps_i,   // from the next cell
  output logic signed [ACC_BITS-1:0]    ps_o    // to the previous cell
);

  localparam int PW = SAMPLE_BITS + COEF_BITS;
  localparam int IW = (TAP_INDEX_BITS > $clog2(MAX_TAPS)) ?
                      TAP_INDEX_BITS : $clog2(MAX_TAPS);

  logic signed [COEF_BITS-1:0] coef_r;
  logic signed [PW-1:0]        prod_full;
  logic signed [ACC_BITS-1:0]  prod_sat;
  logic signed [ACC_BITS-1:0]  prod_r;
  logic signed [ACC_BITS-1:0]  sum_nxt;
  logic                        next_active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (ctrl.coef_we && (IW'(tap_index_i) == IW'(IDX))) begin
      coef_r <= coef_i;
    end
  end

  assign prod_full = x_i * coef_r;

  generate
    if (PW > ACC_BITS) begin : g_prod_sat
      logic [PW-ACC_BITS:0] hi;
      assign hi = prod_full[PW-1:ACC_BITS-1];
      assign prod_sat = ((&hi) || !(|hi)) ? prod_full[ACC_BITS-1:0] :
                        (prod_full[PW-1] ? ACC_MIN : ACC_MAX);
    end else begin : g_prod_ext
      assign prod_sat = ACC_BITS'(prod_full);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_sat;
    end
  end

  assign next_active = CW'(IDX + 1) < teff;
  assign sum_nxt     = acc_add_sat(prod_r, next_active ? ps_i : '0);

  generate
    if (IDX == 0) begin : g_head
      // head cell: its sum is the filter output
      assign ps_o = sum_nxt;
    end else begin : g_tap
      logic                       active;
      logic signed [ACC_BITS-1:0] ps_r;
      assign active = CW'(IDX) < teff;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ps_r <= '0;
        end else if (ctrl.upd_en) begin
          ps_r <= active ? sum_nxt : '0;
        end
      end
      assign ps_o = ps_r;
    end
  endgenerate

endmodule

[hdl/streaming_fir_convolution.sv]
// Top level of the streaming FIR filter: tap-cell chain, sequencer, output rounding.
//
// Input stream (in_*): in_tuser selects the item kind. FUNC_FILTER filters one
// sample, FUNC_COEF writes one coefficient to the cell chosen by tap_index
// (indexes at or beyond MAX_TAPS are dropped). in_tlast is the segment end and
// comes back unchanged on out_tlast. Only sample transfers produce output.
// Output stream (out_*): one rounded, saturated sample per sample transfer.
// Config: cfg_wr_en/cfg_wr_data write tap_count; 0 acts as 1, values above
// MAX_TAPS act as MAX_TAPS. Write only while the filter is idle.
// Timing: a sample goes sample register -> product registers in every cell ->
// partial-sum chain update and holding register together -> output register;
// out_tvalid rises when the output is free. Input is held off while a sample
// is in the chain and while its result sits in the holding register, so a new
// sample waits until the previous one has left the holding register; a
// coefficient transfer leaves the input open.
// A stalled receiver keeps its result in the output register; the next result
// waits in the holding register and input stays blocked until it moves on.
// Reset: partial sums and coefficients clear to zero, tap_count goes to 1,
// the output stream goes empty.
module streaming_fir_convolution
  import sfir_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18,
  localparam int IN_W  = ((SAMPLE_BITS + TAP_INDEX_BITS + COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // in_tdata, low bit up: sample_in, tap_index, coef_value, zero fill
  input  logic [IN_W-1:0]           in_tdata,
  // in_tuser: func
  input  logic                      in_tuser,
  input  logic                      in_tlast,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // out_tdata, low bit up: sample_out, zero fill
  output logic [OUT_W-1:0]          out_tdata,
  output logic                      out_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_wr_en,
  input  logic [TAP_COUNT_BITS-1:0] cfg_wr_data
);

  localparam int CW = (TAP_COUNT_BITS > $clog2(MAX_TAPS + 1)) ?
                      TAP_COUNT_BITS : $clog2(MAX_TAPS + 1);
  localparam int SH = COEF_BITS - 1;           // output shift
  localparam int RW = ACC_BITS + 1 - SH;       // width after the shift
  localparam int TI_LO = SAMPLE_BITS;
  localparam int CF_LO = SAMPLE_BITS + TAP_INDEX_BITS;
  localparam logic signed [ACC_BITS:0] HALF = (ACC_BITS + 1)'(1) << (SH - 1);

  // effective tap count, clamped on write
  logic [CW-1:0] teff_r;
  logic [CW-1:0] cfg_ext;

  assign cfg_ext = CW'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      teff_r <= CW'(1);
    end else if (cfg_wr_en) begin
      priority if (cfg_ext == '0) begin
        teff_r <= CW'(1);
      end else if (cfg_ext > CW'(MAX_TAPS)) begin
        teff_r <= CW'(MAX_TAPS);
      end else begin
        teff_r <= cfg_ext;
      end
    end
  end

  // --- sequencer ---
  logic                          in_xfer;
  logic                          s1_vld_r, s2_vld_r, y_vld_r, out_vld_r;
  logic                          be1_r, be2_r, be3_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [ACC_BITS-1:0]    y_r;
  logic                          y_move;
  cell_ctrl_t                    ctrl;

  // next item enters once the previous sample has left the chain and the holding register
  assign in_tready = !(s1_vld_r || s2_vld_r || y_vld_r);
  assign in_xfer   = in_tvalid && in_tready;
  assign y_move    = y_vld_r && (!out_vld_r || out_tready);

  assign ctrl.coef_we = in_xfer && (in_tuser == FUNC_COEF);
  assign ctrl.mul_en  = s1_vld_r;
  assign ctrl.upd_en  = s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      y_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer && (in_tuser == FUNC_FILTER);
      s2_vld_r <= s1_vld_r;
      if (s2_vld_r) begin
        y_vld_r <= 1'b1;
      end else if (y_move) begin
        y_vld_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r   <= in_tdata[SAMPLE_BITS-1:0];
      be1_r <= in_tlast;
    end
    if (s1_vld_r) begin
      be2_r <= be1_r;
    end
  end

  // --- tap cell chain ---
  logic signed [ACC_BITS-1:0] ps_chain [MAX_TAPS+1];

  assign ps_chain[MAX_TAPS] = '0;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    sfir_cell #(
      .IDX         (i),
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .teff        (teff_r),
      .x_i         (x_r),
      .tap_index_i (in_tdata[CF_LO-1:TI_LO]),
      .coef_i      (in_tdata[CF_LO+COEF_BITS-1:CF_LO]),
      .ps_i        (ps_chain[i+1]),
      .ps_o        (ps_chain[i])
    );
  end

  // head cell sum is the accumulated output, held until the output frees
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      y_r   <= ps_chain[0];
      be3_r <= be2_r;
    end
  end

  // --- round half up, shift, saturate ---
  logic signed [ACC_BITS:0] y_half;
  logic [RW-1:0]            y_sh;
  logic [SAMPLE_BITS-1:0]   y_rnd;

  assign y_half = {y_r[ACC_BITS-1], y_r} + HALF;
  assign y_sh   = y_half[ACC_BITS:SH];

  generate
    if (RW > SAMPLE_BITS) begin : g_out_sat
      logic [RW-SAMPLE_BITS:0] hi;
      assign hi    = y_sh[RW-1:SAMPLE_BITS-1];
      assign y_rnd = ((&hi) || !(|hi)) ? y_sh[SAMPLE_BITS-1:0] :
                     (y_sh[RW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                                   {1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end else begin : g_out_ext
      assign y_rnd = SAMPLE_BITS'(signed'(y_sh));
    end
  endgenerate

  // --- output register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (y_move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (y_move) begin
      out_tdata <= OUT_W'(y_rnd);
      out_tlast <= be3_r;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

[hdl/sfir_checker.sv]
// Port-level checker of the streaming FIR block and its bind to the top level.
`include "streaming_fir_convolution_defines.svh"

module sfir_checker
  import sfir_pkg::*;
#(
  parameter int OUT_W = 24
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tuser,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tvalid,
  input logic             out_tready
);

  // a stalled result holds
  `SFIR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")

  // reset empties the output stream
  `SFIR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  // a sample transfer occupies the chain for the following cycles
  `SFIR_ASSERT(a_sample_busy, in_tvalid && in_tready && (in_tuser == FUNC_FILTER) |=> !in_tready ##1 !in_tready, "input taken while chain busy")

  // a coefficient transfer leaves the input open
  `SFIR_ASSERT(a_coef_free, in_tvalid && in_tready && (in_tuser == FUNC_COEF) |=> in_tready, "coefficient transfer blocked input")

endmodule

bind streaming_fir_convolution sfir_checker #(
  .OUT_W (OUT_W)
) u_sfir_checker (.*);
